/* hw/rtl/sine_tone_generator_assert.svh */
// Assertion macros used by the sine tone generator RTL.
`ifndef SINE_TONE_GENERATOR_ASSERT_SVH
`define SINE_TONE_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define STG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sine tone generator assertion failed");

// Next-cycle implication, disabled while in reset.
`define STG_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sine tone generator assertion failed");

`endif

/* hw/rtl/sinetg_pkg.sv */
// Shared types and constants of the sine tone generator.
`default_nettype none

package sinetg_pkg;

   localparam logic [31:0] PHASE_INC_RESET     = 32'd97391549;
   localparam logic [14:0] AMPLITUDE_RESET     = 15'd6554;
   localparam logic        FLOAT_MODE_RESET    = 1'b0;
   localparam logic [3:0]  CHANNEL_COUNT_RESET = 4'd2;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [14:0] SAMPLE_MAX  = 15'd32767;
   localparam logic [7:0]  EXP_OFFSET  = 8'd97;

   typedef enum logic [1:0] {
      CSR_PHASE_INC     = 2'd0,
      CSR_AMPLITUDE     = 2'd1,
      CSR_FLOAT_MODE    = 2'd2,
      CSR_CHANNEL_COUNT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic restart;
      logic block_end;
   } req_type;

   typedef struct packed {
      logic [31:0] sample_word;
      logic [2:0]  channel_index;
      logic        frame_last;
      logic        block_last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] phase_increment;
      logic [14:0] amplitude;
      logic        float_mode;
      logic [3:0]  channel_count;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic neg;
      logic block_end;
   } stage_ctl_type;

endpackage

`default_nettype wire

/* hw/rtl/sinetg_csr.sv */
// Configuration registers of the sine tone generator.
`default_nettype none

module sinetg_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire sinetg_pkg::csr_index_type  csr_index,
   input  wire logic [31:0]                csr_wdata,
   output sinetg_pkg::cfg_type             cfg
);
   import sinetg_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PHASE_INC:     cfg_in.phase_increment = csr_wdata;
            CSR_AMPLITUDE:     cfg_in.amplitude       = csr_wdata[14:0];
            CSR_FLOAT_MODE:    cfg_in.float_mode      = csr_wdata[0];
            CSR_CHANNEL_COUNT: cfg_in.channel_count   = csr_wdata[3:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_increment <= PHASE_INC_RESET;
         cfg_ff.amplitude       <= AMPLITUDE_RESET;
         cfg_ff.float_mode      <= FLOAT_MODE_RESET;
         cfg_ff.channel_count   <= CHANNEL_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* hw/rtl/sinetg_sine_rom.sv */
// Quarter-wave sine ROM with registered read.
`default_nettype none

module sinetg_sine_rom #(
   parameter int ADDR_BITS = 10
) (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic [ADDR_BITS:0]   addr,
   output logic      [14:0]          data
);
   import sinetg_pkg::*;

   localparam int Depth = (1 << ADDR_BITS) + 1;

   typedef logic [14:0] rom_type [0:Depth-1];

   function automatic rom_type calc_rom();
      rom_type     r;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] q;
      for (int k = 0; k < Depth; k++) begin
         x    = (HALF_PI_Q30 * 64'(k)) >> ADDR_BITS;
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         term = ((term * x2) >> 30) / 64'd6;
         sum  = sum - term;
         term = ((term * x2) >> 30) / 64'd20;
         sum  = sum + term;
         term = ((term * x2) >> 30) / 64'd42;
         sum  = sum - term;
         term = ((term * x2) >> 30) / 64'd72;
         sum  = sum + term;
         term = ((term * x2) >> 30) / 64'd110;
         sum  = sum - term;
         term = ((term * x2) >> 30) / 64'd156;
         sum  = sum + term;
         q    = (sum + 64'd16384) >> 15;
         if (q > 64'(SAMPLE_MAX)) begin
            q = 64'(SAMPLE_MAX);
         end
         r[k] = q[14:0];
      end
      return r;
   endfunction

   localparam rom_type Rom = calc_rom();

   logic [14:0] data_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= Rom[addr];
      end
   end

   assign data = data_ff;

endmodule

`default_nettype wire

/* hw/rtl/sinetg_shaper.sv */
// Amplitude scaling and int16 or float32 sample formatting.
`default_nettype none

module sinetg_shaper (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire sinetg_pkg::stage_ctl_type  in_ctl,
   input  wire logic [14:0]                entry,
   input  wire logic [14:0]                amplitude,
   input  wire logic                       float_mode,
   output sinetg_pkg::stage_ctl_type       out_ctl,
   output logic      [31:0]                word
);
   import sinetg_pkg::*;

   stage_ctl_type ctl2_ff, ctl3_ff;
   logic [29:0]   p_ff, p_in;
   logic [29:0]   p3_ff;
   logic [14:0]   m_ff, m_in;
   logic [4:0]    e_ff, e_in;
   logic [44:0]   prod;

   logic [24:0]   mant;
   logic [7:0]    biased;
   logic [29:0]   shifted;
   logic [29:0]   rem;
   logic [29:0]   half;
   logic [2:0]    rsh;
   logic          round_up;
   logic [31:0]   int_word;
   logic [31:0]   flt_word;

   assign p_in = 30'(amplitude) * 30'(entry);
   assign prod = 45'(p_ff) * 45'(SAMPLE_MAX);
   assign m_in = prod[44:30];

   always_comb begin
      e_in = '0;
      for (int i = 0; i < 30; i++) begin
         if (p_ff[i]) begin
            e_in = 5'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else if (advance) begin
         ctl2_ff <= in_ctl;
         ctl3_ff <= ctl2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff  <= p_in;
         p3_ff <= p_ff;
         m_ff  <= m_in;
         e_ff  <= e_in;
      end
   end

   always_comb begin
      rsh      = 3'(e_ff - 5'd23);
      shifted  = p3_ff >> rsh;
      rem      = p3_ff & ((30'd1 << rsh) - 30'd1);
      half     = 30'd1 << (rsh - 3'd1);
      round_up = (rem > half) || ((rem == half) && shifted[0]);
      if (e_ff <= 5'd23) begin
         mant = {1'b0, p3_ff[23:0] << (5'd23 - e_ff)};
      end else begin
         mant = 25'(shifted) + 25'(round_up);
      end
      biased = 8'(e_ff) + EXP_OFFSET;
      if (mant[24]) begin
         mant   = mant >> 1;
         biased = biased + 8'd1;
      end
      if (p3_ff == '0) begin
         flt_word = '0;
      end else begin
         flt_word = {ctl3_ff.neg, biased, mant[22:0]};
      end
      int_word = ctl3_ff.neg ? (32'd0 - 32'(m_ff)) : 32'(m_ff);
   end

   assign out_ctl = ctl3_ff;
   assign word    = float_mode ? flt_word : int_word;

endmodule

`default_nettype wire

/* hw/rtl/sinetg_serializer.sv */
// Frame register that replays one sample word per channel.
`default_nettype none
`include "sine_tone_generator_assert.svh"

module sinetg_serializer #(
   parameter int MAX_CHANNELS = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire sinetg_pkg::stage_ctl_type  in_ctl,
   input  wire logic [31:0]                in_word,
   input  wire logic [3:0]                 channel_count,
   output logic                            advance,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output sinetg_pkg::rsp_type             rsp_data
);
   import sinetg_pkg::*;

   logic        frame_v_ff, frame_v_in;
   logic [31:0] word_ff;
   logic        blk_ff;
   logic [3:0]  ch_ff, ch_in;
   logic [3:0]  chans;
   logic        last;
   logic        fire;

   always_comb begin
      if (channel_count == 4'd0) begin
         chans = 4'd1;
      end else if (int'(channel_count) > MAX_CHANNELS) begin
         chans = 4'(MAX_CHANNELS);
      end else begin
         chans = channel_count;
      end
   end

   assign last    = (ch_ff + 4'd1) == chans;
   assign fire    = frame_v_ff && rsp_ready;
   assign advance = !frame_v_ff || (rsp_ready && last);

   always_comb begin
      frame_v_in = frame_v_ff;
      ch_in      = ch_ff;
      if (advance) begin
         frame_v_in = in_ctl.valid;
         ch_in      = '0;
      end else if (fire) begin
         ch_in = ch_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_v_ff <= 1'b0;
         ch_ff      <= '0;
      end else begin
         frame_v_ff <= frame_v_in;
         ch_ff      <= ch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= in_word;
         blk_ff  <= in_ctl.block_end;
      end
   end

   assign rsp_valid              = frame_v_ff;
   assign rsp_data.sample_word   = word_ff;
   assign rsp_data.channel_index = ch_ff[2:0];
   assign rsp_data.frame_last    = last;
   assign rsp_data.block_last    = last && blk_ff;

   `STG_ASSERT_NXT(a_ch_step, clock, reset, fire && !last, ch_ff == $past(ch_ff) + 4'd1)
   `STG_ASSERT_NXT(a_drain, clock, reset, fire && last && !in_ctl.valid, !frame_v_ff)
   `STG_ASSERT_NXT(a_busy_hold, clock, reset, frame_v_ff && !fire, frame_v_ff)
   `STG_ASSERT_IMP(a_blk_last, clock, reset, frame_v_ff && blk_ff && last, rsp_data.block_last)

endmodule

`default_nettype wire

/* hw/rtl/sine_tone_generator.sv */
// Top level of the sine tone generator.
//
// Each word accepted on req_ (valid/ready) requests one audio frame. The
// block looks up the sine of the current phase, scales it by the amplitude
// register and then advances the phase by the phase increment. The frame
// value leaves on rsp_ once per channel, channel_index counting up from
// zero, frame_last on the final channel and block_last on the final channel
// of a frame flagged block_end. restart clears the phase for that frame.
// The first rsp_ word of a frame passes the ROM read, scale, format and
// frame registers after the req_ word is accepted. The frame register
// replays each frame once per channel, for max(1, channel_count) channels
// capped at MAX_CHANNELS, one word per cycle while rsp_ready is high;
// frames enter back to back as long as the frame register drains.
// csr_ writes take effect on the next cycle; write them only while idle.
// Reset clears the phase, empties the pipeline and restores the register
// defaults. While the frame register holds a frame, the whole pipeline
// holds and req_ready drops until that frame is fully taken.
`default_nettype none

module sine_tone_generator #(
   parameter int MAX_CHANNELS    = 8,
   parameter int TABLE_ADDR_BITS = 10,
   parameter int PHASE_BITS      = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire sinetg_pkg::req_type        req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output sinetg_pkg::rsp_type             rsp_data,
   input  wire logic                       csr_wr_en,
   input  wire sinetg_pkg::csr_index_type  csr_index,
   input  wire logic [31:0]                csr_wdata
);
   import sinetg_pkg::*;

   localparam int IncW = (PHASE_BITS > 32) ? PHASE_BITS : 32;

   cfg_type                    cfg;
   logic                       advance;
   logic                       accept;
   logic [PHASE_BITS-1:0]      phase_ff, phase_in, ph;
   logic [IncW-1:0]            inc_ext;
   logic [1:0]                 quad;
   logic [TABLE_ADDR_BITS-1:0] idx;
   logic [TABLE_ADDR_BITS:0]   rom_addr;
   logic [14:0]                entry;
   stage_ctl_type              ctl1_ff, ctl1_in;
   stage_ctl_type              ctl3;
   logic [31:0]                word;

   sinetg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign accept  = req_valid && advance;
   assign inc_ext = IncW'(cfg.phase_increment);
   assign ph      = req_data.restart ? '0 : phase_ff;
   assign quad    = ph[PHASE_BITS-1 -: 2];
   assign idx     = ph[PHASE_BITS-3 -: TABLE_ADDR_BITS];
   assign rom_addr = quad[0] ? ({1'b1, {TABLE_ADDR_BITS{1'b0}}} - {1'b0, idx})
                             : {1'b0, idx};
   assign phase_in = accept ? (ph + inc_ext[PHASE_BITS-1:0]) : phase_ff;

   always_comb begin
      ctl1_in.valid     = req_valid;
      ctl1_in.neg       = quad[1];
      ctl1_in.block_end = req_data.block_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         ctl1_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         if (advance) begin
            ctl1_ff <= ctl1_in;
         end
      end
   end

   sinetg_sine_rom #(
      .ADDR_BITS (TABLE_ADDR_BITS)
   ) u_rom (
      .clock (clock),
      .en    (advance),
      .addr  (rom_addr),
      .data  (entry)
   );

   sinetg_shaper u_shaper (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_ctl     (ctl1_ff),
      .entry      (entry),
      .amplitude  (cfg.amplitude),
      .float_mode (cfg.float_mode),
      .out_ctl    (ctl3),
      .word       (word)
   );

   sinetg_serializer #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_serializer (
      .clock         (clock),
      .reset         (reset),
      .in_ctl        (ctl3),
      .in_word       (word),
      .channel_count (cfg.channel_count),
      .advance       (advance),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data)
   );

   assign req_ready = advance;

endmodule

`default_nettype wire
